// ===== design/dit_pkg.sv =====
// Shared types and constants for the disjoint interval tracker.
// Used by the controller, the cell datapath and the top level.
package dit_pkg;

    localparam int MAX_RANGES = 32;
    localparam int VALUE_BITS = 16;
    localparam int IDX_BITS   = $clog2(MAX_RANGES);
    localparam int CNT_BITS   = $clog2(MAX_RANGES + 1);

    localparam logic       REQ_ADD  = 1'b0;
    localparam logic       REQ_READ = 1'b1;

    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_COVERED = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_ENTRY   = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    typedef logic [VALUE_BITS-1:0] value_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_READ,
        S_OUT
    } state_t;

    typedef struct packed {
        logic                load;
        logic                update;
        logic                rd_start;
        logic                rd_advance;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0]          add_status;
        logic [CNT_BITS-1:0] count;
        logic                rd_last;
    } dp_stat_t;

endpackage

// ===== design/dit_datapath.sv =====
// Cell-array datapath: sorted interval registers, parallel compare, shift update.
// Depends on dit_pkg; driven by dit_ctrl commands.
module dit_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  dit_pkg::dp_cmd_t           cmd,
    input  logic [15:0]                in_value,
    output dit_pkg::dp_stat_t          stat,
    output logic [15:0]                rd_low,
    output logic [15:0]                rd_high
);

    localparam int N  = dit_pkg::MAX_RANGES;
    localparam int IB = dit_pkg::IDX_BITS;
    localparam int CB = dit_pkg::CNT_BITS;

    dit_pkg::value_t lo_reg [N];
    dit_pkg::value_t hi_reg [N];
    dit_pkg::value_t lo_next [N];
    dit_pkg::value_t hi_next [N];
    logic [CB-1:0]   count_reg, count_next;
    dit_pkg::value_t v_reg;
    dit_pkg::value_t cmp_v;
    logic [IB-1:0]   rp_reg;
    logic [CB-1:0]   left_cnt_reg;

    logic [N-1:0] valid, below, covered;
    logic [N-1:0] adj_lo, adj_hi;
    logic [N-1:0] b_reg;
    logic [N-1:0] cov_reg, alo_reg, ahi_reg;
    logic         any_cov, any_left, any_right, bridge;
    logic [2:0]   status;

    assign cmp_v = cmd.load ? in_value[dit_pkg::VALUE_BITS-1:0] : v_reg;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            valid[i]   = CB'(i) < count_reg;
            below[i]   = valid[i] && (hi_reg[i] < cmp_v);
            covered[i] = valid[i] && (lo_reg[i] <= cmp_v) && (hi_reg[i] >= cmp_v);
            adj_hi[i]  = valid[i] && (cmp_v != '0) && (hi_reg[i] + 1'b1 == cmp_v);
            adj_lo[i]  = valid[i] && (cmp_v != '1) && (lo_reg[i] == cmp_v + 1'b1);
        end
    end

    // Compare results are registered every cycle (from in_value in the load cycle, from v_reg after); update uses them.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            v_reg <= in_value[dit_pkg::VALUE_BITS-1:0];
        end
        b_reg   <= below;
        cov_reg <= covered;
        alo_reg <= adj_lo;
        ahi_reg <= adj_hi;
    end

    assign any_cov   = |cov_reg;
    assign any_left  = |ahi_reg;
    assign any_right = |alo_reg;
    assign bridge    = any_left && any_right;

    always_comb begin
        if (any_cov) begin
            status = dit_pkg::ST_COVERED;
        end else if (any_left || any_right) begin
            status = dit_pkg::ST_ADDED;
        end else if (count_reg == CB'(N)) begin
            status = dit_pkg::ST_FULL;
        end else begin
            status = dit_pkg::ST_ADDED;
        end
    end

    always_comb begin
        count_next = count_reg;
        for (int i = 0; i < N; i++) begin
            lo_next[i] = lo_reg[i];
            hi_next[i] = hi_reg[i];
        end
        if (cmd.update && !any_cov) begin
            if (bridge) begin
                for (int i = 0; i < N; i++) begin
                    if (ahi_reg[i]) begin
                        hi_next[i] = hi_reg[(i + 1) % N];
                    end else if (i > 0 && !b_reg[i] && !ahi_reg[i]) begin
                        if (i + 1 < N) begin
                            lo_next[i] = lo_reg[i + 1];
                            hi_next[i] = hi_reg[i + 1];
                        end
                    end
                end
                count_next = count_reg - 1'b1;
            end else if (any_left) begin
                for (int i = 0; i < N; i++) begin
                    if (ahi_reg[i]) hi_next[i] = v_reg;
                end
            end else if (any_right) begin
                for (int i = 0; i < N; i++) begin
                    if (alo_reg[i]) lo_next[i] = v_reg;
                end
            end else if (count_reg != CB'(N)) begin
                for (int i = 0; i < N; i++) begin
                    if (b_reg[i]) begin
                        // keep
                    end else if (i == 0 || b_reg[i - 1]) begin
                        lo_next[i] = v_reg;
                        hi_next[i] = v_reg;
                    end else begin
                        lo_next[i] = lo_reg[i - 1];
                        hi_next[i] = hi_reg[i - 1];
                    end
                end
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < N; i++) begin
            lo_reg[i] <= lo_next[i];
            hi_reg[i] <= hi_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_start) begin
            rp_reg       <= '0;
            left_cnt_reg <= count_reg;
        end else if (cmd.rd_advance) begin
            rp_reg       <= rp_reg + 1'b1;
            left_cnt_reg <= left_cnt_reg - 1'b1;
        end
    end

    assign rd_low  = 16'(lo_reg[rp_reg]);
    assign rd_high = 16'(hi_reg[rp_reg]);

    assign stat.add_status = status;
    assign stat.count      = count_reg;
    assign stat.rd_last    = (left_cnt_reg == CB'(1));

endmodule

// ===== design/dit_ctrl.sv =====
// Controller FSM: sequences add and read-out requests and the result register.
// Depends on dit_pkg; commands dit_datapath.
module dit_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_req_type,
    output logic              m_valid,
    input  logic              m_ready,
    output dit_pkg::dp_cmd_t  cmd,
    input  dit_pkg::dp_stat_t stat,
    output logic              out_load,
    output logic [2:0]        out_status,
    output logic              out_entry,
    output logic              out_last
);

    dit_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            free;

    assign free    = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dit_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        s_ready      = 1'b0;
        out_load     = 1'b0;
        out_status   = dit_pkg::ST_ADDED;
        out_entry    = 1'b0;
        out_last     = 1'b1;
        unique case (state_reg)
            dit_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = (s_req_type == dit_pkg::REQ_READ) ?
                                 dit_pkg::S_READ : dit_pkg::S_ADD;
                end
            end
            dit_pkg::S_ADD: begin
                if (free) begin
                    cmd.update   = 1'b1;
                    out_load     = 1'b1;
                    out_status   = stat.add_status;
                    m_valid_next = 1'b1;
                    state_next   = dit_pkg::S_IDLE;
                end
            end
            dit_pkg::S_READ: begin
                cmd.rd_start = 1'b1;
                state_next   = dit_pkg::S_OUT;
                if (stat.count == '0) begin
                    if (free) begin
                        out_load     = 1'b1;
                        out_status   = dit_pkg::ST_EMPTY;
                        m_valid_next = 1'b1;
                        state_next   = dit_pkg::S_IDLE;
                    end else begin
                        state_next   = dit_pkg::S_READ;
                    end
                end
            end
            dit_pkg::S_OUT: begin
                if (free) begin
                    cmd.rd_advance = 1'b1;
                    out_load       = 1'b1;
                    out_status     = dit_pkg::ST_ENTRY;
                    out_entry      = 1'b1;
                    out_last       = stat.rd_last;
                    m_valid_next   = 1'b1;
                    if (stat.rd_last) state_next = dit_pkg::S_IDLE;
                end
            end
            default: state_next = dit_pkg::S_IDLE;
        endcase
    end

endmodule

// ===== design/disjoint_interval_tracker_core.sv =====
// Top level of the disjoint interval tracker.
// Instantiates dit_ctrl and dit_datapath; uses dit_pkg.
//
// Input channel s_*: s_req_type 0 adds s_value to the interval set, 1 reads
// out every interval. Result channel m_*: m_status, m_interval_start,
// m_interval_end, m_last; m_last marks the final result of a request.
// An add presents its one result after the transfer (all cells are compared
// in parallel in the accept cycle, shift/update in S_ADD once the result
// register is free). A read-out gives one result per stored interval, one
// per cycle while m_ready stays high, after the S_READ setup state, or one
// empty-list result. One request is handled at a time; the next is accepted
// once the last result of the previous one is registered.
// Reset empties the table and drops any pending result. When the receiver
// stalls, the result register holds and the controller waits.
module disjoint_interval_tracker_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [15:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_interval_start,
    output logic [15:0] m_interval_end,
    output logic        m_last
);

    dit_pkg::dp_cmd_t  cmd;
    dit_pkg::dp_stat_t stat;
    logic              out_load, out_entry, out_last;
    logic [2:0]        out_status;
    logic [15:0]       rd_low, rd_high;
    logic [2:0]        status_reg;
    logic [15:0]       start_reg, end_reg;
    logic              last_reg;

    dit_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd),
        .stat       (stat),
        .out_load   (out_load),
        .out_status (out_status),
        .out_entry  (out_entry),
        .out_last   (out_last)
    );

    dit_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_value (s_value),
        .stat     (stat),
        .rd_low   (rd_low),
        .rd_high  (rd_high)
    );

    always_ff @(posedge aclk) begin
        if (out_load) begin
            status_reg <= out_status;
            start_reg  <= out_entry ? rd_low : 16'd0;
            end_reg    <= out_entry ? rd_high : 16'd0;
            last_reg   <= out_last;
        end
    end

    assign m_status         = status_reg;
    assign m_interval_start = start_reg;
    assign m_interval_end   = end_reg;
    assign m_last           = last_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.count <= dit_pkg::CNT_BITS'(dit_pkg::MAX_RANGES))
        else $error("interval count out of range");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while busy");

    a_full_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.update && stat.add_status == dit_pkg::ST_FULL) |=> $stable(stat.count))
        else $error("count changed on dropped value");

    a_add_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> (m_valid && m_last))
        else $error("add result not final");

endmodule
